// ----- rtl/tgc_pkg.sv -----
// Shared definitions for the touch gesture classifier: gesture codes,
// register indexes, reset values and default widths. No dependencies.
package tgc_pkg;

  // Default widths of coordinates and timestamps.
  localparam int COORD_BITS_DEF = 12;
  localparam int TIME_BITS_DEF  = 32;

  // Output gesture codes. The controller's swipe ids 1..4 match these.
  localparam int GESTURE_BITS = 3;
  typedef logic [GESTURE_BITS-1:0] gesture_t;
  localparam gesture_t G_NONE  = 3'd0;
  localparam gesture_t G_UP    = 3'd1;
  localparam gesture_t G_DOWN  = 3'd2;
  localparam gesture_t G_LEFT  = 3'd3;
  localparam gesture_t G_RIGHT = 3'd4;
  localparam gesture_t G_TAP   = 3'd5;

  // Controller gesture ids.
  typedef logic [7:0] chip_code_t;
  localparam chip_code_t CHIP_UP    = 8'h01;
  localparam chip_code_t CHIP_RIGHT = 8'h04;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 3;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t REG_ENABLE          = 3'd0;
  localparam cfg_index_t REG_SWIPE_MIN_DIST  = 3'd1;
  localparam cfg_index_t REG_TAP_MAX_DIST    = 3'd2;
  localparam cfg_index_t REG_COORD_LIMIT     = 3'd3;
  localparam cfg_index_t REG_MAX_CONTACT_MS  = 3'd4;
  localparam cfg_index_t REG_RELEASE_TIMEOUT = 3'd5;

  // Register reset values.
  localparam int SWIPE_MIN_DIST_RST  = 40;
  localparam int TAP_MAX_DIST_RST    = 20;
  localparam int COORD_LIMIT_RST     = 280;
  localparam int MAX_CONTACT_MS_RST  = 2000;
  localparam int RELEASE_TIMEOUT_RST = 90;

endpackage

// ----- rtl/touch_gesture_classifier_unit.sv -----
// Touch gesture classifier: turns controller polls into gesture codes.
// Depends on tgc_pkg for gesture codes, register indexes and reset values.
//
//   channel  signals                                     direction  word
//   in       in_valid, in_stall, frame_valid ... now_ms  into block one poll
//   out      out_valid, out_stall, gesture               out of     one gesture
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data   into block one register
//
// The classification and the contact state update are done in the cycle the
// poll is accepted, and the gesture is held in the output register, so a new
// poll is accepted in every cycle unless the input stalls.
// Reset is synchronous; it clears the contact state and loads the register
// defaults. The input stalls only while a gesture waits in the output register
// and the output is stalled. Configuration writes are always ready.
module touch_gesture_classifier_unit #(
  parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = tgc_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // Poll channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         frame_valid,
  input  tgc_pkg::chip_code_t          gesture_code,
  input  logic [7:0]                   finger_count,
  input  logic [COORD_BITS-1:0]        pos_x,
  input  logic [COORD_BITS-1:0]        pos_y,
  input  logic [TIME_BITS-1:0]         now_ms,
  // Gesture channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output tgc_pkg::gesture_t            gesture,
  // Configuration channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  tgc_pkg::cfg_index_t          cfg_index,
  input  logic [TIME_BITS-1:0]         cfg_data
);
  import tgc_pkg::*;

  // Configuration registers.
  logic                  enable;
  logic [COORD_BITS-1:0] swipe_min_dist;
  logic [COORD_BITS-1:0] tap_max_dist;
  logic [COORD_BITS-1:0] coord_limit;
  logic [TIME_BITS-1:0]  max_contact_ms;
  logic [TIME_BITS-1:0]  release_timeout_ms;

  // Contact state.
  logic                  was_down;
  logic                  already_gestured;
  logic [TIME_BITS-1:0]  contact_start_time;
  logic [TIME_BITS-1:0]  last_report_time;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] latest_x;
  logic [COORD_BITS-1:0] latest_y;

  logic                  in_acc;
  logic                  down;
  logic                  timed_out;
  logic                  active;
  logic                  press;
  logic                  hold;
  logic                  release_edge;
  logic [TIME_BITS-1:0]  silence;
  logic [TIME_BITS-1:0]  duration;
  logic                  chip_swipe;
  logic [COORD_BITS:0]   dx;
  logic [COORD_BITS:0]   dy;
  logic [COORD_BITS-1:0] ax;
  logic [COORD_BITS-1:0] ay;
  gesture_t              drag_class;
  gesture_t              gesture_next;

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_acc    = in_valid & ~in_stall;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable             <= 1'b0;
      swipe_min_dist     <= COORD_BITS'(SWIPE_MIN_DIST_RST);
      tap_max_dist       <= COORD_BITS'(TAP_MAX_DIST_RST);
      coord_limit        <= COORD_BITS'(COORD_LIMIT_RST);
      max_contact_ms     <= TIME_BITS'(MAX_CONTACT_MS_RST);
      release_timeout_ms <= TIME_BITS'(RELEASE_TIMEOUT_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:          enable             <= cfg_data[0];
        REG_SWIPE_MIN_DIST:  swipe_min_dist     <= cfg_data[COORD_BITS-1:0];
        REG_TAP_MAX_DIST:    tap_max_dist       <= cfg_data[COORD_BITS-1:0];
        REG_COORD_LIMIT:     coord_limit        <= cfg_data[COORD_BITS-1:0];
        REG_MAX_CONTACT_MS:  max_contact_ms     <= cfg_data;
        REG_RELEASE_TIMEOUT: release_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Contact detection and edge decode. An idle poll only matters once a
  // held contact has been silent past the timeout; it then acts as a release.
  assign down = frame_valid && (finger_count != 8'd0) &&
                (pos_x <= coord_limit) && (pos_y <= coord_limit);
  assign silence   = now_ms - last_report_time;
  assign timed_out = was_down && (silence > release_timeout_ms);
  assign active    = enable && (frame_valid || timed_out);
  assign press        = active && down && !was_down;
  assign hold         = active && down && was_down;
  assign release_edge = active && !down && was_down;
  assign duration     = now_ms - contact_start_time;

  // The controller's swipe ids map straight onto the output codes.
  assign chip_swipe = (gesture_code >= CHIP_UP) && (gesture_code <= CHIP_RIGHT);

  // Drag from the first to the last down position.
  assign dx = {1'b0, latest_x} - {1'b0, start_x};
  assign dy = {1'b0, latest_y} - {1'b0, start_y};
  assign ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
  assign ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];

  // Classification: a swipe needs its axis to be strictly larger, so a tie is a
  // swipe on neither axis; a short drag on both axes is a tap.
  always_comb begin
    if (ax >= swipe_min_dist && ax > ay) begin
      drag_class = dx[COORD_BITS] ? G_LEFT : G_RIGHT;
    end else if (ay >= swipe_min_dist && ay > ax) begin
      drag_class = dy[COORD_BITS] ? G_UP : G_DOWN;
    end else if (ax <= tap_max_dist && ay <= tap_max_dist) begin
      drag_class = G_TAP;
    end else begin
      drag_class = G_NONE;
    end
  end

  // Result selection for this poll.
  always_comb begin
    gesture_next = G_NONE;
    if (hold && !already_gestured && chip_swipe) begin
      gesture_next = gesture_code[GESTURE_BITS-1:0];
    end else if (release_edge && !already_gestured && duration <= max_contact_ms) begin
      gesture_next = drag_class;
    end
  end

  // Contact state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      was_down           <= 1'b0;
      already_gestured   <= 1'b0;
      contact_start_time <= '0;
      last_report_time   <= '0;
      start_x            <= '0;
      start_y            <= '0;
      latest_x           <= '0;
      latest_y           <= '0;
    end else if (in_acc && active) begin
      was_down <= down;
      if (frame_valid) begin
        last_report_time <= now_ms;
      end
      if (press) begin
        contact_start_time <= now_ms;
        already_gestured   <= 1'b0;
        start_x            <= pos_x;
        start_y            <= pos_y;
        latest_x           <= pos_x;
        latest_y           <= pos_y;
      end else if (hold) begin
        latest_x <= pos_x;
        latest_y <= pos_y;
        if (!already_gestured && chip_swipe) begin
          already_gestured <= 1'b1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      gesture <= gesture_next;
    end
  end

`ifndef SYNTH
  // The input only stalls behind a waiting gesture.
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  // Every accepted poll leaves a word in the output register.
  a_acc_gives_word: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid)
    else $error("accepted poll produced no word");

  // A disabled block reports no gesture.
  a_disabled_none: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !enable) |=> (gesture == G_NONE))
    else $error("gesture reported while disabled");

  // Without a held contact there is neither a hold nor a release to report.
  a_no_contact_none: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !was_down) |=> (gesture == G_NONE))
    else $error("gesture reported without a held contact");

  // Only defined gesture codes reach the output.
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gesture <= G_TAP))
    else $error("undefined gesture code");
`endif

endmodule
